>>> rtl/core/tfs_pkg.sv
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the three level feedback scheduler.
// ----------------------------------------------------------------------------
package tfs_pkg;

   // Default build parameters
   localparam int DefQueueDepth = 16;
   localparam int DefTaskIdBits = 8;

   // Field widths
   localparam int AgeBits    = 16;
   localparam int ThrBits    = 15;
   localparam int QuantBits  = 4;
   localparam int LevelBits  = 2;
   localparam int FuncBits   = 2;
   localparam int PaddrBits  = 4;
   localparam int PdataBits  = 32;
   localparam int NumLevels  = 3;

   // Operation codes
   localparam logic [FuncBits-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FuncBits-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FuncBits-1:0] FUNC_NEXT   = 2'd2;
   localparam logic [FuncBits-1:0] FUNC_UNUSED = 2'd3;

   // Level codes
   localparam logic [LevelBits-1:0] LVL_0    = 2'd0;
   localparam logic [LevelBits-1:0] LVL_1    = 2'd1;
   localparam logic [LevelBits-1:0] LVL_2    = 2'd2;
   localparam logic [LevelBits-1:0] LVL_NONE = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_QUANTUM1  = 2'd1;
   localparam logic [1:0] REG_QUANTUM2  = 2'd2;

   // Reset values of the registers
   localparam logic [ThrBits-1:0]   ThrReset = 15'd1000;
   localparam logic [QuantBits-1:0] Q1Reset  = 4'd4;
   localparam logic [QuantBits-1:0] Q2Reset  = 4'd1;

   localparam logic signed [AgeBits-1:0] AgeMax = 16'sh7FFF;

   // Configuration seen by the scheduler core
   typedef struct packed {
      logic [ThrBits-1:0]   aging_threshold;
      logic [QuantBits-1:0] level1_quantum;
      logic [QuantBits-1:0] level2_quantum;
   } cfg_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_NEXT_RD = 4'b0010,
      S_TK_RD   = 4'b0100,
      S_TK_WR   = 4'b1000
   } state_type;

endpackage

>>> rtl/core/tfs_csr.sv
// ----------------------------------------------------------------------------
// tfs_csr
// APB-style register file holding the aging threshold and the two quanta.
// ----------------------------------------------------------------------------
module tfs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tfs_pkg::PaddrBits-1:0] paddr,
   input  logic [tfs_pkg::PdataBits-1:0] pwdata,
   output logic [tfs_pkg::PdataBits-1:0] prdata,
   output logic                          pready,
   output tfs_pkg::cfg_type              cfg
);
   import tfs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_THRESHOLD: cfg_in.aging_threshold = pwdata[ThrBits-1:0];
            REG_QUANTUM1:  cfg_in.level1_quantum  = pwdata[QuantBits-1:0];
            REG_QUANTUM2:  cfg_in.level2_quantum  = pwdata[QuantBits-1:0];
            default: ;
         endcase
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         REG_THRESHOLD: prdata = PdataBits'(cfg_ff.aging_threshold);
         REG_QUANTUM1:  prdata = PdataBits'(cfg_ff.level1_quantum);
         REG_QUANTUM2:  prdata = PdataBits'(cfg_ff.level2_quantum);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aging_threshold <= ThrReset;
         cfg_ff.level1_quantum  <= Q1Reset;
         cfg_ff.level2_quantum  <= Q2Reset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/three_level_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler
// Three FIFO task queues with aging, promotion and level 0 first dispatch.
// ----------------------------------------------------------------------------
// Usage:
//  The req channel takes one word per operation: add (enqueue task_id at
//  task_level with task_age), tick (age and promote) or next (dispatch).
//  Every word yields exactly one rsp word carrying accepted, the grant
//  fields and any_queued. The user must write the registers over the APB-style
//  port only while the block is idle; the block itself does not enforce this.
//  All three queues live in one memory of 3*QUEUE_DEPTH entries with a
//  registered read; each queue is a ring with head, tail, count.
//  A tick reads each entry in S_TK_RD and writes it back, aged or
//  promoted, in S_TK_WR, level by level from level 0 to level 2.
//  One word is in work at a time; req_ready is high when the sequencer is
//  idle and the result register is empty or being drained.
//  A stalled rsp holds its word and blocks new words. Reset empties all
//  queues at once through the counts and loads the register defaults.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler #(
   parameter int QUEUE_DEPTH  = tfs_pkg::DefQueueDepth,
   parameter int TASK_ID_BITS = tfs_pkg::DefTaskIdBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tfs_pkg::FuncBits-1:0]         req_func,
   input  logic [TASK_ID_BITS-1:0]              req_task_id,
   input  logic [tfs_pkg::LevelBits-1:0]        req_task_level,
   input  logic signed [tfs_pkg::AgeBits-1:0]   req_task_age,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_accepted,
   output logic                                 rsp_grant_valid,
   output logic [TASK_ID_BITS-1:0]              rsp_grant_task,
   output logic [tfs_pkg::LevelBits-1:0]        rsp_grant_level,
   output logic [tfs_pkg::QuantBits-1:0]        rsp_grant_quantum,
   output logic signed [tfs_pkg::AgeBits-1:0]   rsp_grant_age,
   output logic                                 rsp_any_queued,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tfs_pkg::PaddrBits-1:0]        paddr,
   input  logic [tfs_pkg::PdataBits-1:0]        pwdata,
   output logic [tfs_pkg::PdataBits-1:0]        prdata,
   output logic                                 pready
);
   import tfs_pkg::*;

   localparam int IdxW   = $clog2(QUEUE_DEPTH);
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam int MemD   = NumLevels * QUEUE_DEPTH;
   localparam int AddrW  = $clog2(MemD);
   localparam int EntryW = TASK_ID_BITS + AgeBits;

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   cfg_type cfg;

   tfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // queue memory
   logic [EntryW-1:0] mem [MemD];
   logic [EntryW-1:0] rd_data_ff;
   logic              mem_we, rd_en;
   logic [AddrW-1:0]  mem_wa, rd_a;
   logic [EntryW-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_en)  rd_data_ff  <= mem[rd_a];
   end

   // control state
   state_type        state_ff, state_in;
   cnt_type          cnt_ff [NumLevels];
   cnt_type          cnt_in [NumLevels];
   idx_type          head_ff [NumLevels];
   idx_type          head_in [NumLevels];
   idx_type          tail_ff [NumLevels];
   idx_type          tail_in [NumLevels];
   logic [LevelBits-1:0] ptr_ff, ptr_in;
   logic [LevelBits-1:0] lvl_ff, lvl_in;   // level in work
   idx_type          rdp_ff, rdp_in;       // tick read position
   idx_type          wp_ff, wp_in;         // tick write-back position
   cnt_type          rem_ff, rem_in;
   cnt_type          keep_ff, keep_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     acc_ff, acc_in;
   logic                     gv_ff, gv_in;
   logic [TASK_ID_BITS-1:0]  gt_ff, gt_in;
   logic [LevelBits-1:0]     gl_ff, gl_in;
   logic [QuantBits-1:0]     gq_ff, gq_in;
   logic [AgeBits-1:0]       ga_ff, ga_in;
   logic                     aq_ff, aq_in;

   function automatic logic [AddrW-1:0] mem_addr(logic [LevelBits-1:0] lvl, idx_type idx);
      mem_addr = AddrW'(lvl * QUEUE_DEPTH) + AddrW'(idx);
   endfunction

   function automatic idx_type wrap_inc(idx_type idx);
      wrap_inc = (idx == IdxW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic                     any_now;
   logic                     done;
   logic [TASK_ID_BITS-1:0]  d_id;
   logic signed [AgeBits-1:0] d_age, aged;
   logic signed [AgeBits-1:0] thr_s;
   logic [LevelBits-1:0]     p;
   logic [LevelBits-1:0]     up;
   logic [QuantBits-1:0]     quant;

   assign any_now = (cnt_ff[0] != '0) || (cnt_ff[1] != '0) || (cnt_ff[2] != '0);
   assign d_id    = rd_data_ff[EntryW-1:AgeBits];
   assign d_age   = rd_data_ff[AgeBits-1:0];
   assign aged    = (d_age == AgeMax) ? d_age : d_age + 16'sd1;
   assign thr_s   = $signed({1'b0, cfg.aging_threshold});
   assign up      = lvl_ff - 1'b1;
   assign quant   = (lvl_ff == LVL_1) ? cfg.level1_quantum : cfg.level2_quantum;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   // level pick for next when level 0 is empty, staying on the last picked level
   always_comb begin
      p = (ptr_ff == LVL_NONE) ? LVL_0 : ptr_ff;
      if (cnt_ff[p[1:0]] == '0) begin
         case (p)
            LVL_0:   p = (cnt_ff[1] != '0) ? LVL_1 : LVL_2;
            LVL_1:   p = LVL_2;
            default: p = LVL_1;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      ptr_in   = ptr_ff;
      lvl_in   = lvl_ff;
      rdp_in   = rdp_ff;
      wp_in    = wp_ff;
      rem_in   = rem_ff;
      keep_in  = keep_ff;
      mem_we   = 1'b0;
      mem_wa   = '0;
      mem_wd   = '0;
      rd_en    = 1'b0;
      rd_a     = '0;
      done     = 1'b0;
      acc_in   = acc_ff;
      gv_in    = gv_ff;
      gt_in    = gt_ff;
      gl_in    = gl_ff;
      gq_in    = gq_ff;
      ga_in    = ga_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               acc_in = 1'b0;
               gv_in  = 1'b0;
               gt_in  = '0;
               gl_in  = '0;
               gq_in  = '0;
               ga_in  = '0;
               case (req_func)
                  FUNC_ADD: begin
                     done = 1'b1;
                     if (req_task_level != LVL_NONE) begin
                        if (cnt_ff[req_task_level] != CntW'(QUEUE_DEPTH)) begin
                           mem_we = 1'b1;
                           mem_wa = mem_addr(req_task_level, tail_ff[req_task_level]);
                           mem_wd = {req_task_id, req_task_age};
                           tail_in[req_task_level] = wrap_inc(tail_ff[req_task_level]);
                           cnt_in[req_task_level]  = cnt_ff[req_task_level] + 1'b1;
                           acc_in = 1'b1;
                        end
                     end
                  end
                  FUNC_TICK: begin
                     if (any_now) begin
                        lvl_in   = LVL_0;
                        rdp_in   = head_ff[0];
                        wp_in    = head_ff[0];
                        rem_in   = cnt_ff[0];
                        keep_in  = '0;
                        state_in = S_TK_RD;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  FUNC_NEXT: begin
                     if (cnt_ff[0] != '0) begin
                        lvl_in   = LVL_0;
                        rd_en    = 1'b1;
                        rd_a     = mem_addr(LVL_0, head_ff[0]);
                        state_in = S_NEXT_RD;
                     end else if (any_now) begin
                        ptr_in   = p;
                        lvl_in   = p;
                        rd_en    = 1'b1;
                        rd_a     = mem_addr(p, head_ff[p[1:0]]);
                        state_in = S_NEXT_RD;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
         end

         // head entry is in the read register
         S_NEXT_RD: begin
            done     = 1'b1;
            state_in = S_IDLE;
            if (lvl_ff == LVL_0 || d_age < thr_s) begin
               head_in[lvl_ff] = wrap_inc(head_ff[lvl_ff]);
               cnt_in[lvl_ff]  = cnt_ff[lvl_ff] - 1'b1;
               gv_in = 1'b1;
               gt_in = d_id;
               gl_in = lvl_ff;
               if (lvl_ff == LVL_0) begin
                  gq_in = '0;
                  ga_in = d_age;
               end else begin
                  gq_in = quant;
                  ga_in = AgeBits'(0) - AgeBits'(quant);
               end
            end
         end

         // issue the next entry read or close the level
         S_TK_RD: begin
            if (rem_ff == '0) begin
               cnt_in[lvl_ff]  = keep_ff;
               tail_in[lvl_ff] = wp_ff;
               if (lvl_ff == LVL_2) begin
                  done     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  lvl_in  = lvl_ff + 1'b1;
                  rdp_in  = head_ff[lvl_ff + 1'b1];
                  wp_in   = head_ff[lvl_ff + 1'b1];
                  rem_in  = cnt_ff[lvl_ff + 1'b1];
                  keep_in = '0;
               end
            end else begin
               rd_en    = 1'b1;
               rd_a     = mem_addr(lvl_ff, rdp_ff);
               state_in = S_TK_WR;
            end
         end

         // age the entry, then promote it or compact it in place
         S_TK_WR: begin
            mem_we = 1'b1;
            if (lvl_ff != LVL_0 && aged >= thr_s && cnt_ff[up] != CntW'(QUEUE_DEPTH)) begin
               mem_wa      = mem_addr(up, tail_ff[up]);
               mem_wd      = {d_id, {AgeBits{1'b0}}};
               tail_in[up] = wrap_inc(tail_ff[up]);
               cnt_in[up]  = cnt_ff[up] + 1'b1;
            end else begin
               mem_wa  = mem_addr(lvl_ff, wp_ff);
               mem_wd  = {d_id, aged};
               wp_in   = wrap_inc(wp_ff);
               keep_in = keep_ff + 1'b1;
            end
            rdp_in   = wrap_inc(rdp_ff);
            rem_in   = rem_ff - 1'b1;
            state_in = S_TK_RD;
         end

         default: state_in = S_IDLE;
      endcase

      aq_in = aq_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         aq_in = (cnt_in[0] != '0) || (cnt_in[1] != '0) || (cnt_in[2] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '{default: '0};
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         ptr_ff       <= LVL_0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      rdp_ff  <= rdp_in;
      wp_ff   <= wp_in;
      rem_ff  <= rem_in;
      keep_ff <= keep_in;
      acc_ff  <= acc_in;
      gv_ff   <= gv_in;
      gt_ff   <= gt_in;
      gl_ff   <= gl_in;
      gq_ff   <= gq_in;
      ga_ff   <= ga_in;
      aq_ff   <= aq_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_grant_valid   = gv_ff;
   assign rsp_grant_task    = gt_ff;
   assign rsp_grant_level   = gl_ff;
   assign rsp_grant_quantum = gq_ff;
   assign rsp_grant_age     = ga_ff;
   assign rsp_any_queued    = aq_ff;

   // queue counts never pass the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CntW'(QUEUE_DEPTH) && cnt_ff[1] <= CntW'(QUEUE_DEPTH)
      && cnt_ff[2] <= CntW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // a dispatch read is always followed by a result
   a_next_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NEXT_RD |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("next did not complete");

   // a taken word leaves the block busy or with a result pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid_ff || state_ff != S_IDLE)
      else $error("request lost");

   // no memory write while a dispatch read is in flight
   a_no_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NEXT_RD |-> !mem_we)
      else $error("write during dispatch read");

endmodule
